// ===== hdl/lpht_pkg.sv =====
// Shared types and constants for the linear-probing hash table.
// Holds op and status codes, field widths and the controller/datapath structs.
// No dependencies.
`default_nettype none

package lpht_pkg;

  // Fixed field widths
  localparam int KEY_W   = 64;
  localparam int HASH_W  = 32;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 9;
  localparam int CNT_W   = 9;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  // Hash modulo unit: remainder bits retired per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = HASH_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture item, start modulo
    logic mod_step;  // one modulo iteration
    logic home;      // go to home slot, issue read
    logic advance;   // step to next slot, issue read
    logic finish;    // apply update, latch result
    logic clr_step;  // clear one slot
    logic emit;      // move result to output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mod_last;  // last modulo iteration this cycle
    logic stop;      // probe ends at the current slot
    logic clr_last;  // last slot of the clearing pass
    logic out_busy;  // output register full and not taken
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/lpht_ctrl.sv =====
// Controller state machine for the linear-probing hash table.
// Sequences clearing, modulo, probing and result hand-off; uses lpht_pkg.
`default_nettype none

module lpht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t     cmd
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HOME,
    S_PROBE,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = S_HOME;
      end
      S_HOME: begin
        cmd.home  = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (sts.stop) begin
          cmd.finish = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    // a config write restarts the clearing pass
    if (cfg_wr_en) begin
      cmd       = '0;
      state_nxt = S_CLEAR;
    end
    in_tready_nxt = (state_nxt == S_IDLE);
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;

`ifndef SYNTHESIS
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (state_r == S_CLEAR))
    else $error("config write did not start clearing pass");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready_r |-> (state_r == S_IDLE))
    else $error("ready asserted outside idle");
`endif

endmodule

`default_nettype wire

// ===== hdl/lpht_dp.sv =====
// Datapath for the linear-probing hash table: slot memory, hash modulo unit,
// probe index, entry count and result/output registers. Uses lpht_pkg.
`default_nettype none

module lpht_dp #(
  parameter int MAX_SLOTS = 256,
  parameter int KEY_BITS  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lpht_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic [lpht_pkg::OP_W-1:0]     in_op,
  input  wire logic [lpht_pkg::KEY_W-1:0]    in_key,
  input  wire logic [lpht_pkg::HASH_W-1:0]   in_hash,
  input  wire logic [lpht_pkg::VAL_W-1:0]    in_value,
  input  wire lpht_pkg::cmd_t                cmd,
  output lpht_pkg::sts_t                     sts,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [lpht_pkg::STAT_W-1:0]        out_status,
  output logic [lpht_pkg::VAL_W-1:0]         out_value
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int NW    = IDX_W + 1;
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int N_RST = (256 > MAX_SLOTS) ? MAX_SLOTS : 256;
  // entry layout, high to low: used, hash, key, value
  localparam int ENT_W = 1 + HASH_W + KEY_BITS + VAL_W;

  // Item and control registers
  logic [OP_W-1:0]      op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [HASH_W-1:0]    hash_r;
  logic [VAL_W-1:0]     val_r;
  logic [NW-1:0]        n_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     tries_r;
  logic [HASH_W-1:0]    sh_r, sh_nxt;
  logic [NW-1:0]        rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] mod_cnt_r;
  logic [CNT_W-1:0]     entry_count_r;
  logic [STAT_W-1:0]    res_status_r, res_status_nxt;
  logic [VAL_W-1:0]     res_value_r, res_value_nxt;
  logic                 out_tvalid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [VAL_W-1:0]     out_value_r;

  // Slot memory
  logic [ENT_W-1:0]     mem [MAX_SLOTS];
  logic [ENT_W-1:0]     rdata_r;
  logic [ENT_W-1:0]     wr_data;
  logic                 wr_en;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;

  logic                 rd_used;
  logic [HASH_W-1:0]    rd_hash;
  logic [KEY_BITS-1:0]  rd_key;
  logic [VAL_W-1:0]     rd_val;
  logic                 hit, empty, sweep_end;
  logic [NW-1:0]        idx_inc;
  logic [IDX_W-1:0]     idx_wrap;
  logic [CW-1:0]        cfg_ext;
  logic [NW-1:0]        n_cfg;
  logic                 put_write, rem_write;

  // Clamp the configured slot count to 1..MAX_SLOTS
  always_comb begin
    cfg_ext = CW'(cfg_wr_data);
    if (cfg_ext == '0)                  n_cfg = NW'(1);
    else if (cfg_ext > CW'(MAX_SLOTS))  n_cfg = NW'(MAX_SLOTS);
    else                                n_cfg = cfg_ext[NW-1:0];
  end

  // Hash modulo: restoring remainder, DIV_BITS bits per cycle
  always_comb begin
    logic [NW:0]       r;
    logic [HASH_W-1:0] s;
    r = {1'b0, rem_r};
    s = sh_r;
    for (int b = 0; b < DIV_BITS; b++) begin
      r = {r[NW-1:0], s[HASH_W-1]};
      s = {s[HASH_W-2:0], 1'b0};
      if (r >= {1'b0, n_r}) r = r - {1'b0, n_r};
    end
    rem_nxt = r[NW-1:0];
    sh_nxt  = s;
  end

  // Probe compare against the registered slot
  assign {rd_used, rd_hash, rd_key, rd_val} = rdata_r;
  assign hit       = rd_used && (rd_hash == hash_r) && (rd_key == key_r);
  assign empty     = !rd_used;
  assign sweep_end = ({1'b0, tries_r} == (n_r - NW'(1)));
  assign idx_inc   = {1'b0, idx_r} + NW'(1);
  assign idx_wrap  = (idx_inc == n_r) ? '0 : idx_inc[IDX_W-1:0];

  // Update and result selection
  assign put_write = (op_r == OP_PUT) && (hit || empty);
  assign rem_write = (op_r == OP_REMOVE) && hit;

  always_comb begin
    res_status_nxt = ST_NOT_FOUND;
    res_value_nxt  = '0;
    case (op_r)
      OP_PUT: begin
        res_status_nxt = (hit || empty) ? ST_OK : ST_FULL;
      end
      OP_GET: begin
        if (hit) begin
          res_status_nxt = ST_OK;
          res_value_nxt  = rd_val;
        end
      end
      OP_REMOVE: begin
        if (hit) res_status_nxt = ST_OK;
      end
      default: begin
        res_status_nxt = ST_NOT_FOUND;
      end
    endcase
  end

  // Memory port selection
  assign wr_en = cmd.clr_step || (cmd.finish && (put_write || rem_write));
  always_comb begin
    if (cmd.clr_step)         wr_data = '0;
    else if (op_r == OP_PUT)  wr_data = {1'b1, hash_r, key_r, val_r};
    else                      wr_data = {1'b0, rd_hash, rd_key, rd_val};
  end
  assign rd_en   = cmd.home || cmd.advance;
  assign rd_addr = cmd.home ? rem_r[IDX_W-1:0] : idx_wrap;

  // Slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[idx_r] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Item capture and modulo state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      key_r  <= in_key[KEY_BITS-1:0];
      hash_r <= in_hash;
      val_r  <= in_value;
      sh_r   <= in_hash;
      rem_r  <= '0;
    end else if (cmd.mod_step) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.home) tries_r <= '0;
    else if (cmd.advance) tries_r <= tries_r + IDX_W'(1);
    if (cmd.finish) begin
      res_status_r <= res_status_nxt;
      res_value_r  <= res_value_nxt;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  // Control registers: slot count, index, counters, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r           <= NW'(N_RST);
      idx_r         <= '0;
      mod_cnt_r     <= '0;
      entry_count_r <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        n_r           <= n_cfg;
        idx_r         <= '0;
        entry_count_r <= '0;
      end else begin
        if (cmd.clr_step)     idx_r <= idx_inc[IDX_W-1:0];
        else if (cmd.home)    idx_r <= rem_r[IDX_W-1:0];
        else if (cmd.advance) idx_r <= idx_wrap;
        if (cmd.finish && (op_r == OP_PUT) && empty) begin
          entry_count_r <= entry_count_r + CNT_W'(1);
        end else if (cmd.finish && rem_write && (entry_count_r != '0)) begin
          entry_count_r <= entry_count_r - CNT_W'(1);
        end
      end
      if (cmd.load)          mod_cnt_r <= '0;
      else if (cmd.mod_step) mod_cnt_r <= mod_cnt_r + DIV_CNT_W'(1);
      if (cmd.emit)          out_tvalid_r <= 1'b1;
      else if (out_tready)   out_tvalid_r <= 1'b0;
    end
  end

  // Status to controller
  always_comb begin
    sts          = '0;
    sts.mod_last = (mod_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    sts.stop     = hit || empty || sweep_end;
    sts.clr_last = (idx_inc == n_r);
    sts.out_busy = out_tvalid_r && !out_tready;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(entry_count_r) <= CW'(n_r))
    else $error("entry count exceeds slots in use");

  a_home_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.home |-> (rem_r < n_r))
    else $error("home slot out of range");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> ({1'b0, idx_r} < n_r))
    else $error("probe index out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/linear_probe_hash_table.sv =====
// Linear-probing hash table, top level. Each input item runs through the hash
// modulo unit (4 bits per cycle), then probes P slots, P = 1 to slots_in_use,
// reading the slot memory (one write and one read port) one slot per cycle, and
// a new item is taken only after the last result is handed to the output.
// rst_n is synchronous, active low; after reset and after each cfg write a
// clearing pass over all slots_in_use slots runs with in_tready low.
`default_nettype none

module linear_probe_hash_table #(
  parameter int MAX_SLOTS = 256,
  parameter int KEY_BITS  = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration: slots_in_use
  input  wire logic                        cfg_wr_en,
  input  wire logic [lpht_pkg::CFG_W-1:0]  cfg_wr_data,
  // input items
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [127:0]                in_tdata,   // key[63:0], key_hash, entry_value
  input  wire logic [1:0]                  in_tuser,   // op
  // result items
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata,  // read_value
  output logic [1:0]                       out_tuser   // status
);
  import lpht_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [KEY_W-1:0]    in_key;
  logic [HASH_W-1:0]   in_hash;
  logic [VAL_W-1:0]    in_value;

  // Unpack input fields
  assign in_key   = in_tdata[63:0];
  assign in_hash  = in_tdata[95:64];
  assign in_value = in_tdata[127:96];

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (in_tuser),
    .in_key      (in_key),
    .in_hash     (in_hash),
    .in_value    (in_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_status  (out_tuser),
    .out_value   (out_tdata)
  );

endmodule

`default_nettype wire
